// ===== hdl/dfr_pkg.sv =====
package dfr_pkg;

  // buffer geometry
  localparam int unsigned BUFFER_DEPTH = 128;
  localparam int unsigned ADDR_W = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;
  // the fill count never reaches the depth, so the address width holds it
  localparam int unsigned CNT_W = ADDR_W;
  localparam int unsigned IDX_W = 7;
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // register reset values
  localparam logic [7:0] START_RESET  = 8'h01;
  localparam logic [7:0] END_RESET    = 8'h04;
  localparam logic [7:0] ESCAPE_RESET = 8'h10;

  // register index within the config block
  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_END    = 2'd1,
    REG_ESCAPE = 2'd2
  } reg_idx_e;

  // beat action codes
  typedef enum logic [1:0] {
    ACT_RX      = 2'd0,
    ACT_READ    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] link_state;
    logic [6:0] stored_count;
    logic       check_ok;
    logic [7:0] computed_check;
    logic [7:0] read_data;
    logic       overflow;
  } out_item_t;

  // framing characters
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
  } cfg_t;

  // frame store access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hdl/dfr_regs.sv =====
module dfr_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dfr_pkg::cfg_t       cfg_o
);

  dfr_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= dfr_pkg::START_RESET;
      cfg_q.end_byte    <= dfr_pkg::END_RESET;
      cfg_q.escape_byte <= dfr_pkg::ESCAPE_RESET;
    end else if (wr_en) begin
      case (dfr_pkg::reg_idx_e'(idx))
        dfr_pkg::REG_START:  cfg_q.start_byte  <= pwdata[7:0];
        dfr_pkg::REG_END:    cfg_q.end_byte    <= pwdata[7:0];
        dfr_pkg::REG_ESCAPE: cfg_q.escape_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    case (dfr_pkg::reg_idx_e'(idx))
      dfr_pkg::REG_START:  prdata = {24'd0, cfg_q.start_byte};
      dfr_pkg::REG_END:    prdata = {24'd0, cfg_q.end_byte};
      dfr_pkg::REG_ESCAPE: prdata = {24'd0, cfg_q.escape_byte};
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== hdl/dfr_mem.sv =====
module dfr_mem (
  input  logic              clk_i,
  input  dfr_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] store_q [dfr_pkg::BUFFER_DEPTH];
  logic [7:0] rdata_q;

  assign rdata_o = rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      store_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= store_q[req_i.raddr];
    end
  end

endmodule

// ===== hdl/dfr_ctrl.sv =====
module dfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dfr_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dfr_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dfr_pkg::out_item_t   out_data_o,
  output dfr_pkg::mem_req_t    mem_req_o,
  input  logic [7:0]           mem_rdata_i
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_ESCAPE  = 2'd2,
    MODE_READY   = 2'd3
  } mode_e;

  localparam int unsigned CNT_W  = dfr_pkg::CNT_W;
  localparam int unsigned CMP_W  = dfr_pkg::CMP_W;
  localparam int unsigned IDX_W  = dfr_pkg::IDX_W;
  localparam int unsigned ADDR_W = dfr_pkg::ADDR_W;

  mode_e               mode_q, mode_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [7:0]          run_q, run_d;
  logic [7:0]          cbl_q, cbl_d;
  logic [7:0]          last_q, last_d;

  logic                s1_valid_q;
  logic                s1_hit_q;
  dfr_pkg::out_item_t  s1_item_q, s1_item_d;
  logic                out_valid_q;
  dfr_pkg::out_item_t  out_item_q, s1_full;

  logic                in_acc, s1_adv, do_store, rd_hit, ovf, special;
  logic [CNT_W:0]      count_inc;
  logic [CMP_W-1:0]    ridx_ext, cnt_ext, cnt_out_ext;
  logic [7:0]          b;

  // pipeline handshake: a result may wait at the output while a new beat enters
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  assign b         = in_data_i.rx_byte;
  assign special   = (b == cfg_i.start_byte) || (b == cfg_i.end_byte) ||
                     (b == cfg_i.escape_byte);
  assign count_inc = {1'b0, count_q} + (CNT_W+1)'(1);
  assign ridx_ext  = CMP_W'(in_data_i.read_index);
  assign cnt_ext   = CMP_W'(count_q);

  // framing state update and store access
  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    run_d     = run_q;
    cbl_d     = cbl_q;
    last_d    = last_q;
    do_store  = 1'b0;
    rd_hit    = 1'b0;
    ovf       = 1'b0;
    mem_req_o = '0;
    if (in_acc) begin
      case (dfr_pkg::action_e'(in_data_i.action))
        dfr_pkg::ACT_RX: begin
          case (mode_q)
            MODE_IDLE: begin
              if (b == cfg_i.start_byte) mode_d = MODE_COLLECT;
            end
            MODE_COLLECT: begin
              if (b == cfg_i.escape_byte) begin
                mode_d = MODE_ESCAPE;
              end else if (b == cfg_i.end_byte) begin
                mode_d = MODE_READY;
              end else if (b == cfg_i.start_byte) begin
                count_d = '0;
                run_d   = '0;
                cbl_d   = '0;
                last_d  = '0;
              end else begin
                do_store = 1'b1;
              end
            end
            MODE_ESCAPE: begin
              mode_d   = MODE_COLLECT;
              do_store = 1'b1;
            end
            default: ;
          endcase
        end
        dfr_pkg::ACT_READ: begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ridx_ext[ADDR_W-1:0];
          rd_hit          = ridx_ext < cnt_ext;
        end
        dfr_pkg::ACT_RELEASE: begin
          mode_d  = MODE_IDLE;
          count_d = '0;
          run_d   = '0;
          cbl_d   = '0;
          last_d  = '0;
        end
        default: ;
      endcase
    end
    // store one byte, drop the frame when the buffer fills
    if (do_store) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = count_q[ADDR_W-1:0];
      mem_req_o.wdata = b;
      cbl_d           = run_q;
      last_d          = b;
      run_d           = run_q ^ b ^ (special ? cfg_i.escape_byte : 8'd0);
      count_d         = count_inc[CNT_W-1:0];
      if (count_inc == (CNT_W+1)'(dfr_pkg::BUFFER_DEPTH)) begin
        ovf     = 1'b1;
        mode_d  = MODE_IDLE;
        count_d = '0;
        run_d   = '0;
        cbl_d   = '0;
        last_d  = '0;
      end
    end
  end

  // result fields as seen after the beat
  assign cnt_out_ext = CMP_W'(count_d);
  always_comb begin
    s1_item_d                = '0;
    s1_item_d.link_state     = mode_d;
    s1_item_d.stored_count   = cnt_out_ext[IDX_W-1:0];
    s1_item_d.check_ok       = (mode_d == MODE_READY) && (count_d != '0) &&
                               (cbl_d == last_d);
    s1_item_d.computed_check = cbl_d;
    s1_item_d.overflow       = ovf;
  end

  // read data joins the result once the memory returns it
  always_comb begin
    s1_full           = s1_item_q;
    s1_full.read_data = s1_hit_q ? mem_rdata_i : 8'd0;
  end

  // state and pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      count_q     <= '0;
      run_q       <= '0;
      cbl_q       <= '0;
      last_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_hit_q    <= 1'b0;
      s1_item_q   <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
      run_q   <= run_d;
      cbl_q   <= cbl_d;
      last_q  <= last_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_hit_q   <= rd_hit;
        s1_item_q  <= s1_item_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        out_item_q  <= s1_full;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/dle_frame_receiver_with_bcc_top.sv =====
// channel   | direction | handshake            | beat
// ----------+-----------+----------------------+--------------------------
// in        | in        | in_valid_i/in_ready_o | dfr_pkg::in_item_t
// out       | out       | out_valid_o/out_ready_i | dfr_pkg::out_item_t
// apb       | in        | psel/penable/pready  | start, end, escape bytes
//
// one beat per cycle while the output is not stalled; a result leaves through
// the frame store read port, then the output register
// reset is asynchronous, active low; the frame store itself is not cleared
// a stalled output holds one result while one more beat is taken in
// config writes are taken in every cycle, pready is tied high
module dle_frame_receiver_with_bcc_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dfr_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dfr_pkg::out_item_t  out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  dfr_pkg::cfg_t     cfg;
  dfr_pkg::mem_req_t mem_req;
  logic [7:0]        mem_rdata;

  dfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dfr_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  dfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

endmodule

// ===== hdl/dfr_checker.sv =====
module dfr_assert (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dfr_pkg::out_item_t  out_data_o
);

  // link state codes as reported in the result beat
  localparam logic [1:0] LINK_IDLE  = 2'd0;
  localparam logic [1:0] LINK_READY = 2'd3;

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input only backs up behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a good check is only reported for a ready frame
  a_check_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.check_ok |-> out_data_o.link_state == LINK_READY)
    else $error("check_ok outside ready state");

  // an overflow leaves an empty idle frame
  a_ovf_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.link_state == LINK_IDLE && out_data_o.stored_count == 7'd0 &&
      out_data_o.computed_check == 8'd0)
    else $error("overflow did not discard frame");

endmodule

bind dle_frame_receiver_with_bcc_top dfr_assert u_dfr_checker (.*);

// ===== tb/dfr_checker.sv =====
module dfr_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  dfr_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  dfr_pkg::out_item_t out_data_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    LINK_IDLE    = 2'd0,
    LINK_COLLECT = 2'd1,
    LINK_ESCAPE  = 2'd2,
    LINK_READY   = 2'd3
  } link_mode_e;

  // shadow of the framing registers and the receiver state
  dfr_pkg::cfg_t      framing;
  link_mode_e         link_mode;
  logic [7:0]         frame_bytes [dfr_pkg::BUFFER_DEPTH];
  int unsigned        fill_count;
  logic [7:0]         running_bcc;
  logic [7:0]         bcc_before_last;
  logic [7:0]         last_byte;

  // status reports still owed by the block, oldest first
  dfr_pkg::out_item_t owed_reports [$];

  function automatic void drop_frame();
    fill_count      = 0;
    running_bcc     = '0;
    bcc_before_last = '0;
    last_byte       = '0;
  endfunction

  // returns 1 when the byte filled the buffer and the frame was thrown away
  function automatic bit store_frame_byte(input logic [7:0] b);
    if (fill_count < dfr_pkg::BUFFER_DEPTH) frame_bytes[fill_count] = b;
    fill_count++;
    bcc_before_last = running_bcc;
    last_byte       = b;
    // framing characters carry the escape value into the check as well
    if (b == framing.start_byte || b == framing.end_byte || b == framing.escape_byte)
      running_bcc ^= framing.escape_byte;
    running_bcc ^= b;
    if (fill_count >= dfr_pkg::BUFFER_DEPTH) begin
      drop_frame();
      link_mode = LINK_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the receiver by one beat and build the status it reports
  function automatic dfr_pkg::out_item_t deframe_step(input dfr_pkg::in_item_t beat);
    dfr_pkg::out_item_t rep;
    logic [7:0]         b;
    logic [7:0]         rdata;
    bit                 ovf;
    b     = beat.rx_byte;
    rdata = '0;
    ovf   = 1'b0;
    case (beat.action)
      dfr_pkg::ACT_RX: begin
        case (link_mode)
          LINK_IDLE: begin
            if (b == framing.start_byte) link_mode = LINK_COLLECT;
          end
          LINK_COLLECT: begin
            // escape wins over end, end over start
            if (b == framing.escape_byte) link_mode = LINK_ESCAPE;
            else if (b == framing.end_byte) link_mode = LINK_READY;
            else if (b == framing.start_byte) begin
              drop_frame();
              link_mode = LINK_COLLECT;
            end else ovf = store_frame_byte(b);
          end
          LINK_ESCAPE: begin
            link_mode = LINK_COLLECT;
            ovf = store_frame_byte(b);
          end
          default: ;
        endcase
      end
      dfr_pkg::ACT_READ: begin
        if (beat.read_index < fill_count) rdata = frame_bytes[beat.read_index];
      end
      dfr_pkg::ACT_RELEASE: begin
        drop_frame();
        link_mode = LINK_IDLE;
      end
      default: ;
    endcase
    rep.link_state     = link_mode;
    rep.stored_count   = 7'(fill_count);
    rep.check_ok       = (link_mode == LINK_READY && fill_count != 0 &&
                          bcc_before_last == last_byte);
    rep.computed_check = bcc_before_last;
    rep.read_data      = rdata;
    rep.overflow       = ovf;
    return rep;
  endfunction

  // watch the channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    dfr_pkg::out_item_t want;
    if (!rst_ni) begin
      framing.start_byte  = dfr_pkg::START_RESET;
      framing.end_byte    = dfr_pkg::END_RESET;
      framing.escape_byte = dfr_pkg::ESCAPE_RESET;
      link_mode           = LINK_IDLE;
      drop_frame();
      owed_reports.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // result beat against the oldest owed report
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (owed_reports.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: report with nothing owed, data %h", $time, out_data_i);
        end else begin
          want = owed_reports.pop_front();
          if (out_data_i !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: report mismatch (expected/actual)", $time);
              $display("  state %0d/%0d count %0d/%0d ok %0b/%0b bcc %02h/%02h",
                       want.link_state, out_data_i.link_state,
                       want.stored_count, out_data_i.stored_count,
                       want.check_ok, out_data_i.check_ok,
                       want.computed_check, out_data_i.computed_check);
              $display("  data %02h/%02h ovf %0b/%0b",
                       want.read_data, out_data_i.read_data,
                       want.overflow, out_data_i.overflow);
            end
          end
        end
      end
      // input beat
      if (in_valid_i && in_ready_i) owed_reports.push_back(deframe_step(in_data_i));
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (dfr_pkg::reg_idx_e'(paddr_i[3:2]))
          dfr_pkg::REG_START:  framing.start_byte  = pwdata_i[7:0];
          dfr_pkg::REG_END:    framing.end_byte    = pwdata_i[7:0];
          dfr_pkg::REG_ESCAPE: framing.escape_byte = pwdata_i[7:0];
          default: ;
        endcase
      end
      pending_o = owed_reports.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_UNUSED = 2'd3;
  localparam int unsigned BEATS_PER_SETUP = 156;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  dfr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dfr_pkg::out_item_t out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [3:0]         paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int checked;

  // framing bytes currently programmed, for building frames
  dfr_pkg::cfg_t link_cfg = '{dfr_pkg::START_RESET, dfr_pkg::END_RESET,
                              dfr_pkg::ESCAPE_RESET};
  int unsigned burst_left  = 0;
  int unsigned beats_sent  = 0;
  int unsigned noise_beats = 0;
  int unsigned frames_sent = 0;
  int unsigned long_frames = 0;
  int unsigned cut_frames  = 0;
  int unsigned cfg_setups  = 1;

  dle_frame_receiver_with_bcc_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dfr_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver stalls: spans of steady, light, heavy or near-total back-pressure
  initial begin
    int unsigned style;
    @(posedge rst_ni);
    forever begin
      style = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk_i);
        case (style)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 3) != 0);
          2: out_ready = $urandom_range(0, 1);
          default: out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic bit is_framing(input logic [7:0] b);
    return b == link_cfg.start_byte || b == link_cfg.end_byte ||
           b == link_cfg.escape_byte;
  endfunction

  // random byte, often one of the framing characters
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return link_cfg.start_byte;
      1: return link_cfg.end_byte;
      2: return link_cfg.escape_byte;
      default: return 8'($urandom);
    endcase
  endfunction

  // one input beat, sent in bursts with random gaps; entered and left at a falling edge
  task automatic send_beat(input logic [1:0] act, input logic [7:0] rx,
                           input logic [6:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    in_data.action     = act;
    in_data.rx_byte    = rx;
    in_data.read_index = idx;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  task automatic write_reg(input dfr_pkg::reg_idx_e idx, input logic [7:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      dfr_pkg::REG_START: link_cfg.start_byte  = value;
      dfr_pkg::REG_END:   link_cfg.end_byte    = value;
      default:            link_cfg.escape_byte = value;
    endcase
  endtask

  // start, escaped payload, check byte, end; optionally broken off at cut_at
  task automatic send_frame(input logic [7:0] payload [$], input bit corrupt,
                            input int cut_at);
    logic [7:0] bcc;
    logic [7:0] b;
    bcc = '0;
    foreach (payload[i]) begin
      if (is_framing(payload[i])) bcc ^= link_cfg.escape_byte;
      bcc ^= payload[i];
    end
    if (corrupt) bcc ^= 8'($urandom_range(1, 255));
    frames_sent++;
    send_beat(dfr_pkg::ACT_RX, link_cfg.start_byte, 7'($urandom));
    for (int i = 0; i <= payload.size(); i++) begin
      b = (i < payload.size()) ? payload[i] : bcc;
      if (i == cut_at) begin
        // abandon by release, release just after an escape, or a fresh start
        cut_frames++;
        case ($urandom_range(0, 2))
          0: send_beat(dfr_pkg::ACT_RELEASE, 8'($urandom), 7'($urandom));
          1: begin
            send_beat(dfr_pkg::ACT_RX, link_cfg.escape_byte, 7'($urandom));
            send_beat(dfr_pkg::ACT_RELEASE, 8'($urandom), 7'($urandom));
          end
          default: send_beat(dfr_pkg::ACT_RX, link_cfg.start_byte, 7'($urandom));
        endcase
        return;
      end
      if (is_framing(b)) send_beat(dfr_pkg::ACT_RX, link_cfg.escape_byte, 7'($urandom));
      send_beat(dfr_pkg::ACT_RX, b, 7'($urandom));
    end
    send_beat(dfr_pkg::ACT_RX, link_cfg.end_byte, 7'($urandom));
  endtask

  // read back some entries, maybe poke the held frame, then usually release
  task automatic close_frame(input int unsigned stored);
    int unsigned top_idx;
    top_idx = (stored > 127) ? 127 : stored;
    repeat ($urandom_range(0, 3))
      send_beat(dfr_pkg::ACT_READ, 8'($urandom),
                $urandom_range(0, 1) ? 7'($urandom_range(0, top_idx)) : 7'($urandom));
    if ($urandom_range(0, 4) == 0)
      send_beat(dfr_pkg::ACT_RX, pick_byte(), 7'($urandom));
    if ($urandom_range(0, 19) != 0)
      send_beat(dfr_pkg::ACT_RELEASE, 8'($urandom), 7'($urandom));
  endtask

  // mostly whole frames with random content, the rest line noise
  task automatic run_traffic(input int unsigned goal);
    logic [7:0]  payload [$];
    int unsigned len;
    int          cut_at;
    while (beats_sent - noise_beats < goal) begin
      if ($urandom_range(0, 99) < 75) begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(120, 130)
                                            : $urandom_range(0, 12);
        if (len >= 120) long_frames++;
        payload.delete();
        repeat (len) payload.push_back(pick_byte());
        cut_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, len)) : -1;
        send_frame(payload, $urandom_range(0, 4) == 0, cut_at);
        close_frame(len + 1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(2'($urandom_range(0, 3)), pick_byte(), 7'($urandom));
          noise_beats++;
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    dfr_pkg::cfg_t setups [7];
    logic [7:0]    payload [$];
    setups[0] = '{8'h00, 8'hFF, 8'h80};
    setups[1] = '{8'hFF, 8'h00, 8'h01};
    setups[2] = '{8'($urandom), 8'($urandom), 8'($urandom)};
    setups[3] = '{8'h5A, 8'h5A, 8'h5A};
    setups[4] = '{8'h7E, 8'h7E, 8'h7D};
    setups[5] = '{8'($urandom), 8'($urandom), 8'($urandom)};
    setups[6] = '{dfr_pkg::START_RESET, dfr_pkg::END_RESET, dfr_pkg::ESCAPE_RESET};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // unused action, stray byte and out-of-range read while idle
    send_beat(ACT_UNUSED, 8'hFF, 7'h7F);
    send_beat(dfr_pkg::ACT_RX, 8'h00, 7'h00);
    send_beat(dfr_pkg::ACT_READ, 8'h00, 7'd127);
    // empty frame reports a bad check
    send_beat(dfr_pkg::ACT_RX, link_cfg.start_byte, 7'h00);
    send_beat(dfr_pkg::ACT_RX, link_cfg.end_byte, 7'h7F);
    send_beat(dfr_pkg::ACT_RELEASE, 8'hFF, 7'h00);
    // escaped start, then a start in mid-frame throws it away
    send_beat(dfr_pkg::ACT_RX, link_cfg.start_byte, 7'h00);
    send_beat(dfr_pkg::ACT_RX, link_cfg.escape_byte, 7'h00);
    send_beat(dfr_pkg::ACT_RX, link_cfg.start_byte, 7'h00);
    send_beat(dfr_pkg::ACT_RX, 8'hAA, 7'h00);
    // good frame with byte extremes and an escaped end byte
    payload = '{8'h00, 8'hFF, dfr_pkg::END_RESET};
    send_frame(payload, 1'b0, -1);
    // held frame ignores bytes, reads inside and past the count
    send_beat(dfr_pkg::ACT_RX, 8'h55, 7'h00);
    send_beat(dfr_pkg::ACT_READ, 8'h00, 7'd0);
    send_beat(dfr_pkg::ACT_READ, 8'h00, 7'd2);
    send_beat(dfr_pkg::ACT_READ, 8'h00, 7'd3);
    send_beat(dfr_pkg::ACT_READ, 8'h00, 7'd127);
    send_beat(ACT_UNUSED, 8'h00, 7'h00);
    send_beat(dfr_pkg::ACT_RELEASE, 8'h00, 7'h7F);

    run_traffic(BEATS_PER_SETUP);
    for (int p = 0; p < 7; p++) begin
      // drain before touching the framing registers
      in_valid = 1'b0;
      while (pending != 0) @(negedge clk_i);
      write_reg(dfr_pkg::REG_START, setups[p].start_byte);
      write_reg(dfr_pkg::REG_END, setups[p].end_byte);
      write_reg(dfr_pkg::REG_ESCAPE, setups[p].escape_byte);
      cfg_setups++;
      run_traffic(BEATS_PER_SETUP * (p + 2));
    end

    // let the last reports come out
    in_valid = 1'b0;
    for (int k = 0; k < 20000 && pending != 0; k++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("%0d beats, %0d frames (%0d long, %0d cut short) over %0d framing setups",
             beats_sent, frames_sent, long_frames, cut_frames, cfg_setups);
    $display("%0d status reports checked, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      if (pending != 0) $display("%0d status reports never arrived", pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dfr_pkg.sv
hdl/dfr_regs.sv
hdl/dfr_mem.sv
hdl/dfr_ctrl.sv
hdl/dle_frame_receiver_with_bcc_top.sv
hdl/dfr_checker.sv
tb/dfr_checker.sv
tb/testbench.sv
